// File: hw/rtl/pds_pkg.sv
// ----------------------------------------------------------------------------
// pds_pkg
// Shared widths, limits, beat types and state encoding of the PLL divider
// search.
// ----------------------------------------------------------------------------
package pds_pkg;

  localparam int unsigned XtalW   = 26;
  localparam int unsigned TargetW = 28;
  localparam int unsigned MW      = 6;
  localparam int unsigned NW      = 9;
  localparam int unsigned PW      = 4;
  localparam int unsigned FreqW   = 28;
  localparam int unsigned VinW    = 21;
  localparam int unsigned VcoW    = 30;
  localparam int unsigned Q6W     = 28;
  localparam int unsigned A6W     = 19;
  localparam int unsigned CntW    = $clog2(XtalW);

  localparam logic [MW-1:0]    MFirst     = MW'(2);
  localparam logic [MW-1:0]    MLast      = MW'(63);
  localparam logic [NW-1:0]    NLast      = NW'(432);
  localparam logic [MW-1:0]    DivSix     = MW'(6);
  localparam logic [XtalW-1:0] VcoInMin   = XtalW'(1000000);
  localparam logic [XtalW-1:0] VcoInMax   = XtalW'(2000000);
  localparam logic [VcoW-1:0]  VcoOutMin  = VcoW'(100000000);
  localparam logic [VcoW-1:0]  VcoOutMax  = VcoW'(432000000);
  localparam logic [VcoW-2:0]  OutMax     = (VcoW-1)'(180000000);

  typedef struct packed {
    logic [XtalW-1:0]   crystal_hz;
    logic [TargetW-1:0] target_hz;
  } pds_in_t;

  typedef struct packed {
    logic             found;
    logic [MW-1:0]    m_div;
    logic [NW-1:0]    n_mult;
    logic [PW-1:0]    p_div;
    logic [FreqW-1:0] out_hz;
  } pds_out_t;

  typedef struct packed {
    logic             start;
    logic [XtalW-1:0] dividend;
    logic [MW-1:0]    divisor;
  } pds_div_req_t;

  typedef struct packed {
    logic             done;
    logic [XtalW-1:0] quotient;
    logic [MW-1:0]    remainder;
  } pds_div_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD_M,
    ST_DIV_M,
    ST_LOAD_6,
    ST_DIV_6,
    ST_SCAN,
    ST_DONE
  } pds_state_e;

endpackage

// File: hw/rtl/pds_stream_if.sv
// ----------------------------------------------------------------------------
// pds_stream_if
// Valid/ready channel carrying one beat of payload type T.
// ----------------------------------------------------------------------------
interface pds_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/pds_div.sv
// ----------------------------------------------------------------------------
// pds_div
// Bit-serial restoring divider: one quotient bit per cycle, 26-bit dividend
// by a 6-bit divisor.
// ----------------------------------------------------------------------------
module pds_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pds_pkg::pds_div_req_t req_i,
  output pds_pkg::pds_div_rsp_t rsp_o
);
  import pds_pkg::*;

  localparam logic [CntW-1:0] CntLast = CntW'(XtalW - 1);

  logic             busy_q, done_q;
  logic [CntW-1:0]  cnt_q;
  logic [XtalW-1:0] quo_q;
  logic [MW-1:0]    rem_q, dvs_q;
  logic [MW:0]      shifted, diff;
  logic             ge;

  assign shifted = {rem_q, quo_q[XtalW-1]};
  assign ge      = shifted >= {1'b0, dvs_q};
  assign diff    = shifted - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CntW'(1);
      if (cnt_q == CntLast) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= ge ? diff[MW-1:0] : shifted[MW-1:0];
      quo_q <= {quo_q[XtalW-2:0], ge};
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && !req_i.start |=> !done_q)
    else $error("divider done held longer than one cycle");

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider done while still busy");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> rem_q < dvs_q)
    else $error("divider remainder not below divisor");

endmodule

// File: hw/rtl/pll_divider_search.sv
// ----------------------------------------------------------------------------
// pll_divider_search
// Exhaustive M/N/P search for the highest PLL output frequency not above
// a target.
// ----------------------------------------------------------------------------
// One input beat (crystal, target) yields one result beat. For each M from 2
// to 63 a bit-serial divider forms crystal/M after a load state; when that
// lies in 1..2 MHz a second pass forms its quotient and remainder by six,
// then N steps up from zero, the VCO value and its sixth kept by
// accumulation, trying P = 2, 4, 6, 8 on each N whose VCO lies in
// 100..432 MHz and stopping once the VCO passes 432 MHz. A new beat is
// taken only once the previous search has finished; the result register
// lets that beat in while the last result still waits on the output.
// ----------------------------------------------------------------------------
module pll_divider_search (
  input  logic                clk_i,
  input  logic                rst_ni,
  pds_stream_if.sink          in_i,
  pds_stream_if.source        out_o
);
  import pds_pkg::*;

  pds_state_e state_q, state_d;

  logic [XtalW-1:0]   xtal_q;
  logic [TargetW-1:0] target_q;
  logic [MW-1:0]      m_q;
  logic [NW-1:0]      n_q;
  logic [1:0]         p_idx_q;
  logic [VinW-1:0]    vin_q;
  logic [A6W-1:0]     a6_q;
  logic [2:0]         b6_q;
  logic [VcoW-1:0]    vco_q;
  logic [Q6W-1:0]     q6_q;
  logic [3:0]         r6_q;
  logic [MW-1:0]      best_m_q;
  logic [NW-1:0]      best_n_q;
  logic [PW-1:0]      best_p_q;
  logic [FreqW-1:0]   best_f_q;
  pds_out_t           out_q;
  logic               out_valid_q;

  pds_div_req_t div_req;
  pds_div_rsp_t div_rsp;

  logic            in_ready, out_load, out_free;
  logic            vin_ok, vco_ok, step_n, end_m, next_m, cand;
  logic [VcoW-2:0] f_sel;
  logic [3:0]      r6_sum;
  logic            r6_wrap;
  logic [PW-1:0]   p_val;

  pds_div u_div (
    .clk_i,
    .rst_ni,
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  assign vin_ok   = div_rsp.quotient >= VcoInMin && div_rsp.quotient <= VcoInMax;
  assign vco_ok   = vco_q >= VcoOutMin && vco_q <= VcoOutMax;
  assign step_n   = (state_q == ST_SCAN) && (!vco_ok || p_idx_q == 2'd3);
  assign end_m    = step_n && (n_q == NLast || vco_q > VcoOutMax);
  assign next_m   = (state_q == ST_DIV_M && div_rsp.done && !vin_ok) || end_m;
  assign out_free = !out_valid_q || out_o.ready;
  assign p_val    = PW'({p_idx_q, 1'b0}) + PW'(2);

  always_comb begin
    unique case (p_idx_q)
      2'd0:    f_sel = vco_q[VcoW-1:1];
      2'd1:    f_sel = {1'b0, vco_q[VcoW-1:2]};
      2'd2:    f_sel = (VcoW-1)'(q6_q);
      default: f_sel = {2'b00, vco_q[VcoW-1:3]};
    endcase
  end

  assign cand = (state_q == ST_SCAN) && vco_ok && f_sel <= OutMax
              && f_sel <= (VcoW-1)'(target_q) && f_sel > (VcoW-1)'(best_f_q);

  assign r6_sum  = r6_q + {1'b0, b6_q};
  assign r6_wrap = r6_sum >= 4'd6;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_i.valid) state_d = ST_LOAD_M;
      ST_LOAD_M: state_d = ST_DIV_M;
      ST_DIV_M: begin
        if (div_rsp.done) begin
          if (vin_ok)            state_d = ST_LOAD_6;
          else if (m_q == MLast) state_d = ST_DONE;
          else                   state_d = ST_LOAD_M;
        end
      end
      ST_LOAD_6: state_d = ST_DIV_6;
      ST_DIV_6:  if (div_rsp.done) state_d = ST_SCAN;
      ST_SCAN: begin
        if (end_m) state_d = (m_q == MLast) ? ST_DONE : ST_LOAD_M;
      end
      ST_DONE:   if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready         = state_q == ST_IDLE;
    out_load         = (state_q == ST_DONE) && out_free;
    div_req.start    = (state_q == ST_LOAD_M) || (state_q == ST_LOAD_6);
    div_req.dividend = (state_q == ST_LOAD_6) ? XtalW'(vin_q) : xtal_q;
    div_req.divisor  = (state_q == ST_LOAD_6) ? DivSix : m_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load)         out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      xtal_q   <= in_i.data.crystal_hz;
      target_q <= in_i.data.target_hz;
      m_q      <= MFirst;
      best_m_q <= '0;
      best_n_q <= '0;
      best_p_q <= '0;
      best_f_q <= '0;
    end
    if (next_m) m_q <= m_q + MW'(1);
    if (state_q == ST_DIV_M && div_rsp.done) vin_q <= div_rsp.quotient[VinW-1:0];
    if (state_q == ST_DIV_6 && div_rsp.done) begin
      a6_q    <= div_rsp.quotient[A6W-1:0];
      b6_q    <= div_rsp.remainder[2:0];
      n_q     <= '0;
      vco_q   <= '0;
      q6_q    <= '0;
      r6_q    <= '0;
      p_idx_q <= '0;
    end
    if (state_q == ST_SCAN) begin
      if (step_n) begin
        n_q     <= n_q + NW'(1);
        vco_q   <= vco_q + VcoW'(vin_q);
        q6_q    <= q6_q + Q6W'(a6_q) + Q6W'(r6_wrap);
        r6_q    <= r6_wrap ? r6_sum - 4'd6 : r6_sum;
        p_idx_q <= '0;
      end else begin
        p_idx_q <= p_idx_q + 2'd1;
      end
    end
    if (cand) begin
      best_m_q <= m_q;
      best_n_q <= n_q;
      best_p_q <= p_val;
      best_f_q <= f_sel[FreqW-1:0];
    end
    if (out_load) begin
      out_q.found  <= best_f_q != '0;
      out_q.m_div  <= best_m_q;
      out_q.n_mult <= best_n_q;
      out_q.p_div  <= best_p_q;
      out_q.out_hz <= best_f_q;
    end
  end

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  a_r6_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |-> r6_q < 4'd6)
    else $error("sixth remainder out of range");

  a_vin_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |-> XtalW'(vin_q) >= VcoInMin && XtalW'(vin_q) <= VcoInMax)
    else $error("scan running on out-of-range reference");

  a_found_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q.found == (out_q.m_div != '0) && out_q.found == (out_q.p_div != '0))
    else $error("result fields disagree with found flag");

endmodule

// File: sim/pll_divider_search_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pll_divider_search_test
// Self-checking bench for the PLL divider search. Requests of crystal and
// target frequency go in over a valid/ready channel; each returned divider
// set is checked field by field against an exhaustive M/N/P search done in
// the bench. Both channels idle at random, the result side holds off for a
// long stretch once, and all traffic drains after the first two phases.
// ----------------------------------------------------------------------------
module pll_divider_search_test;
  import pds_pkg::*;

  localparam int unsigned HalfPeriod   = 5;
  localparam int unsigned RxHoldCycles = 20000;
  localparam int unsigned TailCycles   = 2000;
  localparam int unsigned VinLow       = 1000000;
  localparam int unsigned VinHigh      = 2000000;
  localparam int unsigned VcoLow       = 100000000;
  localparam int unsigned VcoHigh      = 432000000;
  localparam int unsigned OutCeiling   = 180000000;

  logic clk_i;
  logic rst_ni;

  pds_stream_if #(.T(pds_in_t))  req_if ();
  pds_stream_if #(.T(pds_out_t)) rsp_if ();

  pll_divider_search dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (rsp_if)
  );

  pds_in_t     request_q[$];
  pds_out_t    expected_sets_q[$];
  int unsigned mismatches;
  logic        req_taken;
  logic        idle_on;
  logic        hold_go;
  logic        rx_hold;
  int unsigned tx_gap;
  int unsigned rx_gap;

  always begin
    clk_i = 1'b1;
    #(HalfPeriod);
    clk_i = 1'b0;
    #(HalfPeriod);
  end

  function automatic pds_out_t best_divider_set(input pds_in_t beat);
    pds_out_t    best;
    logic [31:0] vin;
    logic [31:0] vco;
    logic [31:0] f;
    best = '0;
    for (int unsigned m = 2; m <= 63; m++) begin
      vin = beat.crystal_hz / m;
      if (vin >= VinLow && vin <= VinHigh) begin
        for (int unsigned n = 50; n <= 432; n++) begin
          vco = vin * n;
          if (vco >= VcoLow && vco <= VcoHigh) begin
            for (int unsigned p = 2; p <= 8; p += 2) begin
              f = vco / p;
              if (f <= OutCeiling && f <= beat.target_hz && f > best.out_hz) begin
                best.m_div  = MW'(m);
                best.n_mult = NW'(n);
                best.p_div  = PW'(p);
                best.out_hz = FreqW'(f);
              end
            end
          end
        end
      end
    end
    best.found = (best.out_hz != '0);
    return best;
  endfunction

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (!idle_on) return 0;
    if (r < 10) return $urandom_range(0, 3);
    if (r < 14) return $urandom_range(4, 20);
    return $urandom_range(50, 400);
  endfunction

  function automatic pds_in_t rand_request();
    pds_in_t     beat;
    int unsigned sel;
    int unsigned tsel;
    sel  = $urandom_range(0, 19);
    tsel = $urandom_range(0, 7);
    if (sel < 4) beat.crystal_hz = XtalW'($urandom_range(0, 2100000));
    else if (sel < 14) beat.crystal_hz = XtalW'($urandom_range(2000000, 16000000));
    else if (sel < 18) beat.crystal_hz = XtalW'($urandom_range(16000000, 40000000));
    else beat.crystal_hz = XtalW'($urandom());
    if (tsel == 0) beat.target_hz = TargetW'($urandom());
    else if (tsel == 1) beat.target_hz = TargetW'($urandom_range(0, 20000000));
    else beat.target_hz = TargetW'($urandom_range(12000000, 190000000));
    return beat;
  endfunction

  task automatic queue_request(input int unsigned crystal, input int unsigned target);
    pds_in_t beat;
    beat.crystal_hz = XtalW'(crystal);
    beat.target_hz  = TargetW'(target);
    request_q.push_back(beat);
  endtask

  task automatic drain_all();
    while (request_q.size() != 0 || req_if.valid) @(posedge clk_i);
    while (expected_sets_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic flag_mismatch(input string what, input int unsigned want,
                               input int unsigned got);
    if (mismatches < 10)
      $display("MISMATCH %s: expected %0d, got %0d at %0t", what, want, got, $time);
    mismatches++;
  endtask

  // Request side: advance to the next beat once the current one is taken.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else if (!req_if.valid || req_taken) begin
      if (tx_gap != 0) begin
        tx_gap       <= tx_gap - 1;
        req_if.valid <= 1'b0;
      end else if (request_q.size() != 0) begin
        req_if.data  <= request_q.pop_front();
        req_if.valid <= 1'b1;
        tx_gap       <= idle_len();
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // Result side: random stalls, plus the long hold.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else if (rx_hold) begin
      rsp_if.ready <= 1'b0;
    end else if (rx_gap != 0) begin
      rx_gap       <= rx_gap - 1;
      rsp_if.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 3) == 0) begin
      rx_gap       <= idle_len();
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : watch
    pds_out_t want;
    pds_out_t got;
    if (!rst_ni) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= req_if.valid && req_if.ready;
      if (req_if.valid && req_if.ready)
        expected_sets_q.push_back(best_divider_set(req_if.data));
      if (rsp_if.valid && rsp_if.ready) begin
        got = rsp_if.data;
        if (expected_sets_q.size() == 0) begin
          flag_mismatch("unexpected result beat, out_hz", 0, got.out_hz);
        end else begin
          want = expected_sets_q.pop_front();
          if (got.found !== want.found) flag_mismatch("found", want.found, got.found);
          if (got.m_div !== want.m_div) flag_mismatch("m_div", want.m_div, got.m_div);
          if (got.n_mult !== want.n_mult) flag_mismatch("n_mult", want.n_mult, got.n_mult);
          if (got.p_div !== want.p_div) flag_mismatch("p_div", want.p_div, got.p_div);
          if (got.out_hz !== want.out_hz) flag_mismatch("out_hz", want.out_hz, got.out_hz);
        end
      end
    end
  end

  initial begin
    rx_hold = 1'b0;
    while (hold_go !== 1'b1) @(posedge clk_i);
    rx_hold = 1'b1;
    repeat (RxHoldCycles) @(posedge clk_i);
    rx_hold = 1'b0;
  end

  initial begin
    #(500_000_000);
    $display("pll_divider_search verification failed");
    $finish;
  end

  initial begin
    rst_ni       = 1'b0;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    rsp_if.ready = 1'b0;
    mismatches   = 0;
    tx_gap       = 0;
    rx_gap       = 0;
    idle_on      = 1'b1;
    hold_go      = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    queue_request(0, 0);
    queue_request(67108863, 268435455);
    queue_request(1999999, 268435455);
    queue_request(2000000, 268435455);
    queue_request(8000000, 168000000);
    queue_request(8000000, 180000000);
    queue_request(8000000, 180000001);
    queue_request(25000000, 100000000);
    queue_request(12000000, 48000000);
    queue_request(8000000, 12499999);
    queue_request(8000000, 12500000);
    queue_request(64000000, 180000000);
    queue_request(4000000, 0);
    queue_request(16000000, 1);
    queue_request(3999999, 96000000);
    queue_request(50000000, 150000000);
    queue_request(10000000, 134217728);
    queue_request(3000000, 1);
    drain_all();

    // Hold the result side while quick requests pile up behind it.
    hold_go = 1'b1;
    for (int i = 0; i < 6; i++)
      queue_request($urandom_range(0, 1999999), $urandom());
    drain_all();

    idle_on = 1'b0;
    for (int i = 0; i < 15; i++) request_q.push_back(rand_request());
    while (request_q.size() != 0) @(posedge clk_i);
    idle_on = 1'b1;
    for (int i = 0; i < 80; i++) request_q.push_back(rand_request());
    drain_all();
    repeat (TailCycles) @(posedge clk_i);

    if (mismatches == 0 && expected_sets_q.size() == 0) begin
      $display("pll_divider_search verification clean");
    end else begin
      $display("pll_divider_search verification failed");
    end
    $finish;
  end

endmodule
